### rtl/brf_pkg.sv
// Shared types, codes and constants for the bisection root finder.
package brf_pkg;

  localparam int unsigned SCAN_POINTS_DEF = 200;
  localparam int unsigned MAX_ROUNDS_DEF  = 100;

  localparam int unsigned CFG_W   = 31;
  localparam int unsigned ROUND_W = 8;
  localparam int unsigned PHASE_W = 3;

  localparam logic [CFG_W-1:0] TOL_RESET = 31'd7;
  localparam logic [CFG_W-1:0] FIN_RESET = 31'd655;

  // configuration register indexes
  localparam logic REG_TOLERANCE    = 1'b0;
  localparam logic REG_FINAL_ACCEPT = 1'b1;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  // result kinds
  localparam logic KIND_PROBE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_END_A  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_END_B  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SCAN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BISECT = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FINAL  = 3'd5;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] sample_value;
    logic               sample_invalid;
  } brf_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_point;
    logic signed [31:0] y_value;
    logic               found;
  } brf_out_t;

  // scan step magnitude and sign from the divider
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } brf_step_t;

endpackage

### rtl/brf_step_div.sv
// Scan step divider: (x_high - x_low) / SCAN_POINTS by reciprocal multiply, two stages.
module brf_step_div #(
  parameter int unsigned SCAN_POINTS = brf_pkg::SCAN_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output brf_pkg::brf_step_t step_o
);
  import brf_pkg::*;

  // exact floor division for any 32 bit dividend (round-up reciprocal)
  localparam int unsigned SHIFT = 32 + $clog2(SCAN_POINTS);
  localparam logic [63:0] RECIP_W =
    ((64'd1 << SHIFT) + 64'(SCAN_POINTS) - 64'd1) / 64'(SCAN_POINTS);
  localparam logic [32:0] RECIP = RECIP_W[32:0];

  logic signed [32:0] diff;
  logic [32:0]        mag_abs;
  logic [31:0]        mag_q;
  logic               neg_q;
  logic [64:0]        prod;
  logic [64:0]        prod_sh;
  brf_step_t          step_d, step_q;

  always_comb begin
    diff    = 33'(hi_i) - 33'(lo_i);
    mag_abs = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag_q <= mag_abs[31:0];
      neg_q <= diff[32];
    end
  end

  always_comb begin
    prod       = 65'(mag_q) * 65'(RECIP);
    prod_sh    = prod >> SHIFT;
    step_d.mag = prod_sh[31:0];
    step_d.neg = neg_q;
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign step_o = step_q;

endmodule

### rtl/brf_core.sv
// Search sequencer: phase state, bounds, scan and bisection decisions, config registers.
module brf_core #(
  parameter int unsigned SCAN_POINTS = brf_pkg::SCAN_POINTS_DEF,
  parameter int unsigned MAX_ROUNDS  = brf_pkg::MAX_ROUNDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [brf_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       accept_i,
  input  brf_pkg::brf_in_t           in_i,
  input  brf_pkg::brf_step_t         step_i,
  output logic                       push_o,
  output brf_pkg::brf_out_t          res_o
);
  import brf_pkg::*;

  localparam int unsigned IDX_W = $clog2(SCAN_POINTS + 1);

  // control state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               end_ok_q, end_ok_d;
  logic               prev_inv_q, prev_inv_d;
  logic [CFG_W-1:0]   tol_q, tol_d;
  logic [CFG_W-1:0]   fin_q, fin_d;

  // datapath state
  logic signed [31:0] a_q, a_d;
  logic signed [31:0] b_q, b_d;
  logic signed [31:0] va_q, va_d;
  logic signed [31:0] step_q, step_d;
  logic signed [31:0] prev_pt_q, prev_pt_d;
  logic signed [31:0] prev_y_q, prev_y_d;
  logic signed [31:0] probe_q, probe_d;

  logic signed [31:0] fv;
  logic               bad;
  logic signed [31:0] step_val;
  logic signed [32:0] sum_ab, sum_sc, sum_nb;
  logic signed [32:0] width;
  logic [32:0]        abs_fv;
  logic               small_fv, half_ok, final_ok;
  logic               va_zero, fv_zero, prev_zero, opp_a, scan_hit;
  logic signed [31:0] nb_a, nb_b, nb_va;
  logic [ROUND_W-1:0] round_nx;

  always_comb begin
    fv       = in_i.sample_value;
    bad      = in_i.sample_invalid;
    step_val = step_i.neg ? 32'(-$signed({1'b0, step_i.mag})) : $signed(step_i.mag);

    sum_ab   = 33'(a_q) + 33'(b_q);
    sum_sc   = 33'(prev_pt_q) + 33'(probe_q);
    width    = 33'(b_q) - 33'(a_q);
    abs_fv   = fv[31] ? 33'(-33'(fv)) : 33'(fv);
    small_fv = abs_fv < {2'b00, tol_q};
    final_ok = abs_fv < {2'b00, fin_q};
    half_ok  = 34'(width) < $signed({2'b00, tol_q, 1'b0});

    va_zero   = (va_q == '0);
    fv_zero   = (fv == '0);
    prev_zero = (prev_y_q == '0);
    opp_a     = !va_zero && !fv_zero && (va_q[31] != fv[31]);
    scan_hit  = !bad && !prev_inv_q && (prev_zero || fv_zero || (prev_y_q[31] != fv[31]));

    // bisection update of the bracket
    nb_a  = a_q;
    nb_b  = b_q;
    nb_va = va_q;
    if (bad || opp_a) begin
      nb_b = probe_q;
    end else begin
      nb_a  = probe_q;
      nb_va = fv;
    end
    sum_nb   = 33'(nb_a) + 33'(nb_b);
    round_nx = round_q + 1'b1;
  end

  always_comb begin
    phase_d    = phase_q;
    round_d    = round_q;
    idx_d      = idx_q;
    end_ok_d   = end_ok_q;
    prev_inv_d = prev_inv_q;
    tol_d      = tol_q;
    fin_d      = fin_q;
    a_d        = a_q;
    b_d        = b_q;
    va_d       = va_q;
    step_d     = step_q;
    prev_pt_d  = prev_pt_q;
    prev_y_d   = prev_y_q;
    probe_d    = probe_q;
    push_o     = 1'b0;
    res_o      = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOLERANCE:    tol_d = cfg_wdata_i;
        REG_FINAL_ACCEPT: fin_d = cfg_wdata_i;
        default:          ;
      endcase
    end

    if (accept_i) begin
      if (in_i.cmd == CMD_START) begin
        a_d        = in_i.x_low;
        b_d        = in_i.x_high;
        phase_d    = PH_END_A;
        probe_d    = in_i.x_low;
        push_o     = 1'b1;
        res_o.kind = KIND_PROBE;
        res_o.x_point = in_i.x_low;
      end else begin
        case (phase_q)
          PH_END_A: begin
            va_d          = fv;
            end_ok_d      = !bad;
            phase_d       = PH_END_B;
            probe_d       = b_q;
            push_o        = 1'b1;
            res_o.kind    = KIND_PROBE;
            res_o.x_point = b_q;
          end
          PH_END_B: begin
            push_o = 1'b1;
            if (!end_ok_q || bad) begin
              phase_d    = PH_IDLE;
              res_o.kind = KIND_VERDICT;
            end else if (!va_zero && !fv_zero && (va_q[31] == fv[31])) begin
              // same sign at both ends: scan for a sign change
              step_d        = step_val;
              prev_pt_d     = a_q;
              prev_y_d      = va_q;
              prev_inv_d    = 1'b0;
              idx_d         = IDX_W'(1);
              phase_d       = PH_SCAN;
              probe_d       = a_q + step_val;
              res_o.kind    = KIND_PROBE;
              res_o.x_point = a_q + step_val;
            end else begin
              phase_d       = PH_BISECT;
              round_d       = '0;
              probe_d       = sum_ab[32:1];
              res_o.kind    = KIND_PROBE;
              res_o.x_point = sum_ab[32:1];
            end
          end
          PH_SCAN: begin
            push_o = 1'b1;
            if (scan_hit) begin
              a_d           = prev_pt_q;
              b_d           = probe_q;
              va_d          = prev_y_q;
              phase_d       = PH_BISECT;
              round_d       = '0;
              probe_d       = sum_sc[32:1];
              res_o.kind    = KIND_PROBE;
              res_o.x_point = sum_sc[32:1];
            end else begin
              prev_inv_d = bad;
              prev_pt_d  = probe_q;
              prev_y_d   = fv;
              if (idx_q >= IDX_W'(SCAN_POINTS)) begin
                phase_d    = PH_IDLE;
                res_o.kind = KIND_VERDICT;
              end else begin
                idx_d         = idx_q + 1'b1;
                probe_d       = probe_q + step_q;
                res_o.kind    = KIND_PROBE;
                res_o.x_point = probe_q + step_q;
              end
            end
          end
          PH_BISECT: begin
            push_o = 1'b1;
            if (!bad && (small_fv || half_ok)) begin
              phase_d       = PH_IDLE;
              res_o.kind    = KIND_VERDICT;
              res_o.x_point = probe_q;
              res_o.y_value = fv;
              res_o.found   = 1'b1;
            end else begin
              a_d     = nb_a;
              b_d     = nb_b;
              va_d    = nb_va;
              round_d = round_nx;
              if (round_nx >= ROUND_W'(MAX_ROUNDS)) begin
                phase_d = PH_FINAL;
              end
              probe_d       = sum_nb[32:1];
              res_o.kind    = KIND_PROBE;
              res_o.x_point = sum_nb[32:1];
            end
          end
          PH_FINAL: begin
            push_o     = 1'b1;
            phase_d    = PH_IDLE;
            res_o.kind = KIND_VERDICT;
            if (!bad && final_ok) begin
              res_o.x_point = probe_q;
              res_o.y_value = fv;
              res_o.found   = 1'b1;
            end
          end
          default: begin
            // reply with no search running: dropped
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      round_q    <= '0;
      idx_q      <= '0;
      end_ok_q   <= 1'b0;
      prev_inv_q <= 1'b0;
      tol_q      <= TOL_RESET;
      fin_q      <= FIN_RESET;
    end else begin
      phase_q    <= phase_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
      end_ok_q   <= end_ok_d;
      prev_inv_q <= prev_inv_d;
      tol_q      <= tol_d;
      fin_q      <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    va_q      <= va_d;
    step_q    <= step_d;
    prev_pt_q <= prev_pt_d;
    prev_y_q  <= prev_y_d;
    probe_q   <= probe_d;
  end

  a_final_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FINAL |-> round_q == ROUND_W'(MAX_ROUNDS))
    else $error("final phase entered with wrong round count");

  a_bisect_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BISECT |-> round_q < ROUND_W'(MAX_ROUNDS))
    else $error("bisection ran past the round limit");

  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SCAN |-> (idx_q != '0) && (idx_q <= IDX_W'(SCAN_POINTS)))
    else $error("scan index out of range");

  a_verdict_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.kind == KIND_VERDICT |=> phase_q == PH_IDLE)
    else $error("search still running after a verdict");

endmodule

### rtl/brf_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module brf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  brf_pkg::brf_out_t data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output brf_pkg::brf_out_t out_data_o,
  output logic              full_o
);
  import brf_pkg::*;

  logic     main_vld_q, main_vld_d;
  logic     skid_vld_q, skid_vld_d;
  brf_out_t main_q, main_d;
  brf_out_t skid_q, skid_d;
  logic     pop;

  always_comb begin
    pop        = main_vld_q && out_ready_i;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_d     = data_i;
        skid_vld_d = push_i;
      end else begin
        main_d     = data_i;
        main_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;
  assign full_o      = skid_vld_q;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held with empty output register");

endmodule

### rtl/bisection_root_finder.sv
// Bisection root finder top level: input handshake, sequencer, step divider, result buffer.
//
// The block steers an outside function evaluator through a bracketing root search in
// signed Q16.16. A start transaction (cmd 0) carries x_low and x_high; every accepted
// transaction then yields one result, either a probe (kind 0) telling the evaluator
// which x to evaluate, or a final verdict (kind 1) with the root, its value and the
// found flag. The evaluator answers each probe with a reply transaction (cmd 1)
// holding f(x) and an invalid flag for NaN/Inf. Both ends are probed first; if they
// share a nonzero sign the interval is scanned in SCAN_POINTS equal steps for a sign
// change, then bisection runs for up to MAX_ROUNDS rounds with an early stop on
// |f| < tolerance or a half width below tolerance, and a last midpoint is accepted if
// |f| < final_accept. A reply with no search running is dropped and gives no result;
// a start abandons any running search. Each transaction is decided in the cycle it is
// accepted and its result is registered in the output buffer, so one transaction per
// clock is sustained while the buffer has room. The output side has an output register
// and a skid register, so input ready drops only when both hold results. The scan step,
// computed as (x_high - x_low) / SCAN_POINTS by a two-stage reciprocal multiplier
// started by the start transaction, is ready before the second end-point reply can
// arrive. The configuration (tolerance at index 0, final_accept at index 1) is written
// through cfg_we_i; the user must do so only while the block is idle (not enforced).
module bisection_root_finder #(
  parameter int unsigned SCAN_POINTS = brf_pkg::SCAN_POINTS_DEF,
  parameter int unsigned MAX_ROUNDS  = brf_pkg::MAX_ROUNDS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [brf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  brf_pkg::brf_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output brf_pkg::brf_out_t         out_data_o
);
  import brf_pkg::*;

  logic      accept;
  logic      buf_full;
  logic      push;
  brf_out_t  res;
  brf_step_t step;

  // ready depends only on the skid slot, never on the output side's ready
  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;

  brf_step_div #(
    .SCAN_POINTS(SCAN_POINTS)
  ) u_div (
    .clk_i (clk_i),
    .load_i(accept && (in_data_i.cmd == CMD_START)),
    .lo_i  (in_data_i.x_low),
    .hi_i  (in_data_i.x_high),
    .step_o(step)
  );

  brf_core #(
    .SCAN_POINTS(SCAN_POINTS),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .step_i     (step),
    .push_o     (push),
    .res_o      (res)
  );

  brf_out_buf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .full_o     (buf_full)
  );

  // every start transaction produces a probe, so a result must be pending right after
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.cmd == CMD_START |=> out_valid_o)
    else $error("start transaction produced no result");

endmodule
